// ===== hdl/framed_word_deframer_crc16_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the framed word deframer
// Each macro expands to one labeled concurrent assertion on clk, which is
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef FRAMED_WORD_DEFRAMER_CRC16_ASSERT_SVH
`define FRAMED_WORD_DEFRAMER_CRC16_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWDCRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWDCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fwdcrc_pkg.sv =====
// ---------------------------------------------------------------------------
// fwdcrc_pkg
// Shared types, constants and CRC-16/MCRF4XX helpers for the deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package fwdcrc_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned MAX_WORDS = 256;
  localparam int unsigned COUNT_W  = $clog2(MAX_WORDS + 1);

  localparam logic [WORD_W-1:0] START_WORD = 16'h0226;
  localparam logic [WORD_W-1:0] END_WORD   = 16'h0218;
  localparam logic [WORD_W-1:0] CRC_INIT   = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY   = 16'h8408;

  localparam logic [CFG_W-1:0] MAX_WORDS_RESET = CFG_W'(256);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_BODY  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_GOOD     = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] index;
    logic               last;
    status_t            status;
  } result_t;

  // Reflected CRC, one byte, LSB first.
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Upper byte goes in first, as it came first on the link.
  function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc,
                                                 input logic [WORD_W-1:0] w);
    return crc_byte(crc_byte(crc, w[15:8]), w[7:0]);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fwdcrc_fsm.sv =====
// ---------------------------------------------------------------------------
// fwdcrc_fsm
// Frame state, word count and running CRC; decides the result for one word.
// ---------------------------------------------------------------------------
`default_nettype none

module fwdcrc_fsm (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [fwdcrc_pkg::CFG_W-1:0]    max_words,
  input  wire logic                            step,
  input  wire logic [fwdcrc_pkg::WORD_W-1:0]   word,
  output logic                                 res_valid,
  output fwdcrc_pkg::result_t                  res
);

  fwdcrc_pkg::phase_t                    phase, phase_next;
  logic [fwdcrc_pkg::COUNT_W-1:0]        word_count, word_count_next;
  logic [fwdcrc_pkg::WORD_W-1:0]         running_crc, running_crc_next;
  logic [fwdcrc_pkg::CFG_W-1:0]          limit;

  // The register may hold more than the frame buffer allows.
  assign limit = (max_words > fwdcrc_pkg::CFG_W'(fwdcrc_pkg::MAX_WORDS))
               ? fwdcrc_pkg::CFG_W'(fwdcrc_pkg::MAX_WORDS) : max_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fwdcrc_pkg::PH_HUNT;
      word_count  <= '0;
      running_crc <= fwdcrc_pkg::CRC_INIT;
    end else if (step) begin
      phase       <= phase_next;
      word_count  <= word_count_next;
      running_crc <= running_crc_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    word_count_next  = word_count;
    running_crc_next = running_crc;
    res_valid        = 1'b0;
    res.word         = word;
    res.index        = word_count[fwdcrc_pkg::INDEX_W-1:0];
    res.last         = 1'b0;
    res.status       = fwdcrc_pkg::ST_DATA;

    if (fwdcrc_pkg::CFG_W'(word_count) >= limit) begin
      res_valid        = 1'b1;
      res.last         = 1'b1;
      res.status       = fwdcrc_pkg::ST_OVERFLOW;
      phase_next       = fwdcrc_pkg::PH_HUNT;
      word_count_next  = '0;
      running_crc_next = fwdcrc_pkg::CRC_INIT;
    end else begin
      case (phase)
        fwdcrc_pkg::PH_BODY: begin
          if (word == fwdcrc_pkg::END_WORD) begin
            phase_next = fwdcrc_pkg::PH_CHECK;
          end else begin
            running_crc_next = fwdcrc_pkg::crc_word(running_crc, word);
          end
          word_count_next = word_count + fwdcrc_pkg::COUNT_W'(1);
          res_valid       = 1'b1;
        end
        fwdcrc_pkg::PH_CHECK: begin
          res_valid        = 1'b1;
          res.last         = 1'b1;
          res.status       = (word == running_crc) ? fwdcrc_pkg::ST_GOOD
                                                   : fwdcrc_pkg::ST_CRC_ERR;
          phase_next       = fwdcrc_pkg::PH_HUNT;
          word_count_next  = '0;
          running_crc_next = fwdcrc_pkg::CRC_INIT;
        end
        default: begin
          // Hunting; the unused phase code behaves the same way.
          if (word == fwdcrc_pkg::START_WORD) begin
            running_crc_next = fwdcrc_pkg::crc_word(fwdcrc_pkg::CRC_INIT, word);
            phase_next       = fwdcrc_pkg::PH_BODY;
            word_count_next  = fwdcrc_pkg::COUNT_W'(1);
            res_valid        = 1'b1;
            res.index        = '0;
          end else begin
            phase_next = fwdcrc_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/framed_word_deframer_crc16.sv =====
// Pipeline: an accepted beat is held in the input register, then its result
//   in the result register; a stalled output keeps the beat in the input register.
// Throughput: one input beat per cycle, limited only by the result register
//   being drained; the 16-bit CRC update is combinational.
// Reset (rst, synchronous): hunting for the start word, count zero, CRC 0xFFFF,
//   max_words 256, both pipeline registers empty.
// ---------------------------------------------------------------------------
// framed_word_deframer_crc16
// Finds frames between the start word and the end word, passes their words
// through with their positions, and checks the trailing CRC-16/MCRF4XX word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "framed_word_deframer_crc16_assert.svh"

module framed_word_deframer_crc16 (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration: frame length limit.
  input  wire logic                               cfg_wr_en,
  input  wire logic [fwdcrc_pkg::CFG_W-1:0]       cfg_wr_data,
  // Input beats.
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [fwdcrc_pkg::WORD_W-1:0]      in_word,
  // Result beats.
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [fwdcrc_pkg::WORD_W-1:0]           out_word,
  output logic [fwdcrc_pkg::INDEX_W-1:0]          word_index,
  output logic                                    frame_last,
  output logic [1:0]                              frame_status
);

  logic [fwdcrc_pkg::CFG_W-1:0]  max_words;

  // Input register.
  logic                          s1_valid;
  logic [fwdcrc_pkg::WORD_W-1:0] s1_word;

  // Result register.
  fwdcrc_pkg::result_t           out_res;

  logic                          step;
  logic                          fsm_res_valid;
  fwdcrc_pkg::result_t           fsm_res;

  // The held word is processed whenever the result register is free or is
  // being emptied in this same cycle, so words can stream one per cycle.
  assign step     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_words <= fwdcrc_pkg::MAX_WORDS_RESET;
    end else if (cfg_wr_en) begin
      max_words <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_word;
    end
  end

  fwdcrc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .max_words (max_words),
    .step      (step),
    .word      (s1_word),
    .res_valid (fsm_res_valid),
    .res       (fsm_res)
  );

  // A dropped word still consumes the step but loads nothing; a waiting
  // result that is taken in that cycle simply leaves the register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= fsm_res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && fsm_res_valid) begin
      out_res <= fsm_res;
    end
  end

  assign out_word     = out_res.word;
  assign word_index   = out_res.index;
  assign frame_last   = out_res.last;
  assign frame_status = out_res.status;

  // Only terminal results close a frame.
  `FWDCRC_ASSERT_SAME(a_last_matches_status, out_valid,
    frame_last == (frame_status != fwdcrc_pkg::ST_DATA), "frame_last disagrees with status")

  // Back-pressure on the input comes only from a full pipe with a stalled output.
  `FWDCRC_ASSERT_SAME(a_ready_only_when_full, !in_ready,
    s1_valid && out_valid && !out_ready, "input stalled without output stall")

  // A produced result is on the output in the next cycle.
  `FWDCRC_ASSERT_NEXT(a_result_loaded, step && fsm_res_valid,
    out_valid, "result was not loaded into the output register")

endmodule

`default_nettype wire

// ===== test/framed_word_deframer_crc16_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deframer result checker
// Watches the configuration port and both beat channels. It keeps its own
// copy of the frame hunter, word count and running CRC-16/MCRF4XX, predicts
// the result of every accepted input beat, and compares each accepted result
// beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module framed_word_deframer_crc16_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [fwdcrc_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [fwdcrc_pkg::WORD_W-1:0]      in_word,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [fwdcrc_pkg::WORD_W-1:0]      out_word,
  input  wire logic [fwdcrc_pkg::INDEX_W-1:0]     word_index,
  input  wire logic                               frame_last,
  input  wire logic [1:0]                         frame_status,
  output int                                      fail_count,
  output int                                      pending
);
  import fwdcrc_pkg::*;

  phase_t                hunt_phase;
  logic [COUNT_W-1:0]    stored_words;
  logic [WORD_W-1:0]     frame_crc;
  logic [CFG_W-1:0]      frame_limit;
  result_t               frame_results_due[$];
  int                    n_mismatch;

  // Reflected CRC update over one word, upper byte first.
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    acc = c;
    for (int b = 1; b >= 0; b--) begin
      acc = acc ^ {8'h00, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  function automatic void restart_hunt();
    hunt_phase   = PH_HUNT;
    stored_words = '0;
    frame_crc    = CRC_INIT;
  endfunction

  function automatic void deframe_word(input logic [WORD_W-1:0] w);
    int unsigned lim;
    result_t     r;
    lim = (frame_limit > MAX_WORDS) ? MAX_WORDS : frame_limit;
    r.word  = w;
    r.index = stored_words[INDEX_W-1:0];
    r.last  = 1'b0;
    r.status = ST_DATA;
    // The length limit wins over everything, even while hunting.
    if (stored_words >= lim) begin
      r.last   = 1'b1;
      r.status = ST_OVERFLOW;
      frame_results_due.push_back(r);
      restart_hunt();
    end else if (hunt_phase == PH_BODY) begin
      if (w == END_WORD) hunt_phase = PH_CHECK;
      else frame_crc = crc_feed(frame_crc, w);
      stored_words = stored_words + COUNT_W'(1);
      frame_results_due.push_back(r);
    end else if (hunt_phase == PH_CHECK) begin
      r.last   = 1'b1;
      r.status = (w == frame_crc) ? ST_GOOD : ST_CRC_ERR;
      frame_results_due.push_back(r);
      restart_hunt();
    end else if (w == START_WORD) begin
      frame_crc    = crc_feed(CRC_INIT, w);
      hunt_phase   = PH_BODY;
      stored_words = COUNT_W'(1);
      frame_results_due.push_back(r);
    end
  endfunction

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      n_mismatch++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (frame_results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h/%0d/%b/%0d", $time,
               out_word, word_index, frame_last, frame_status);
      n_mismatch++;
    end else begin
      want = frame_results_due.pop_front();
      check_field("out_word", want.word, out_word);
      check_field("word_index", 16'(want.index), 16'(word_index));
      check_field("frame_last", 16'(want.last), 16'(frame_last));
      check_field("frame_status", 16'(want.status), 16'(frame_status));
    end
  endfunction

  // A result beat can never stem from an input beat of the same edge, so the
  // result side is checked before the new prediction is queued.
  always @(posedge clk) begin
    if (rst) begin
      restart_hunt();
      frame_limit = MAX_WORDS_RESET;
      frame_results_due.delete();
      n_mismatch = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) deframe_word(in_word);
      if (cfg_wr_en) frame_limit = cfg_wr_data;
    end
    fail_count <= n_mismatch;
    pending    <= frame_results_due.size();
  end

endmodule

// ===== test/framed_word_deframer_crc16_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for framed_word_deframer_crc16
// Sends directed frames and noise, then randomized well-formed, corrupted and
// broken frames under several frame length limits and three idling patterns.
// A checker beside the block predicts and compares every result beat; this
// top only drives stimulus, runs the watchdog and prints the verdict.
// ---------------------------------------------------------------------------
module framed_word_deframer_crc16_tb;
  import fwdcrc_pkg::*;

  // Longest run of cycles without any beat before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [WORD_W-1:0]   in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_word;
  logic [INDEX_W-1:0]  word_index;
  logic                frame_last;
  logic [1:0]          frame_status;

  int                  fail_count;
  int                  pending;

  // Percent of cycles in which the sender holds back a beat and the receiver
  // refuses one. They change between the three stimulus phases.
  int                  src_idle_pct = 24;
  int                  sink_idle_pct = 56;

  int unsigned         cur_limit = MAX_WORDS;
  int unsigned         frame_words = 0;
  int                  stall_cycles = 0;
  logic [WORD_W-1:0]   frame_body[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  framed_word_deframer_crc16 DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .word_index   (word_index),
    .frame_last   (frame_last),
    .frame_status (frame_status)
  );

  framed_word_deframer_crc16_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .word_index   (word_index),
    .frame_last   (frame_last),
    .frame_status (frame_status),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // The receiver decides afresh every cycle whether it takes a result beat.
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // The watchdog restarts on every beat on either channel. A block that hangs,
  // or that never delivers a predicted result, ends the run here.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // The CRC that a well-behaved transmitter appends. It is computed one bit
  // at a time, so it shares no structure with the byte-wise update used by
  // the checker. Bits go in LSB first within each byte, upper byte first.
  function automatic logic [WORD_W-1:0] link_crc(input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    logic              fb;
    acc = c;
    for (int i = 0; i < 16; i++) begin
      fb  = acc[0] ^ w[(i < 8) ? i + 8 : i - 8];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Body words lean toward the start word and the all-zero and all-one
  // patterns. The end word is never used, since it would close the frame.
  function automatic logic [WORD_W-1:0] body_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 15))
      0: w = START_WORD;
      1: w = 16'hFFFF;
      2: w = 16'h0000;
      default: w = 16'($urandom);
    endcase
    if (w == END_WORD) w = ~w;
    return w;
  endfunction

  // One input beat. Valid stays up from the previous beat when no gap is
  // taken, so it is never lowered and raised within one time step.
  task automatic put_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every predicted result has come back, then let a
  // dropped word that may still be in the pipeline pass through.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = (v > MAX_WORDS) ? MAX_WORDS : v;
  endtask

  task automatic fill_body(input int unsigned len);
    frame_body.delete();
    repeat (len) frame_body.push_back(body_word());
  endtask

  // Start word, the body held in frame_body, end word and the check word,
  // which is flipped in a random nonzero pattern when a bad CRC is wanted.
  task automatic send_frame(input bit crc_ok);
    logic [WORD_W-1:0] crc;
    crc = link_crc(CRC_INIT, START_WORD);
    put_word(START_WORD);
    foreach (frame_body[i]) begin
      crc = link_crc(crc, frame_body[i]);
      put_word(frame_body[i]);
    end
    put_word(END_WORD);
    put_word(crc_ok ? crc : crc ^ 16'($urandom_range(1, 16'hFFFF)));
    frame_words += frame_body.size() + 3;
  endtask

  // Random traffic under one frame length limit. Most of it is complete
  // frames; the rest is line noise and frames of random words after the start word.
  // Halfway through, the sender waits until every result is back.
  task automatic random_setting(input logic [CFG_W-1:0] v, input int unsigned target);
    int unsigned goal;
    int unsigned span;
    int unsigned n;
    int unsigned pick;
    bit          paused;
    write_limit(v);
    goal   = frame_words + target;
    span   = (cur_limit < 40) ? cur_limit : 40;
    paused = 1'b0;
    while (frame_words < goal) begin
      if (!paused && frame_words + target / 2 >= goal) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Mostly short frames; now and then one long enough to overflow.
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, span);
        else n = $urandom_range(0, (cur_limit < 10) ? cur_limit : 10);
        fill_body(n);
        send_frame($urandom_range(0, 3) != 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) put_word(16'($urandom));
      end else begin
        // Any word may follow here, the end word included, so such a frame
        // ends in a CRC check on random data or runs into the limit.
        n = $urandom_range(0, span + 1);
        put_word(START_WORD);
        repeat (n) put_word(16'($urandom));
        frame_words += n + 1;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first with the limit left at its reset value.
    // Words outside a frame are dropped, the end word among them.
    put_word(16'h0000);
    put_word(16'hFFFF);
    put_word(END_WORD);
    // A good frame with all-one and all-zero body words.
    frame_body = '{16'hFFFF, 16'h0000};
    send_frame(1'b1);
    // A frame whose check word does not match.
    frame_body = '{16'h1234};
    send_frame(1'b0);
    // The shortest frame: start word, end word, check word.
    frame_body.delete();
    send_frame(1'b1);
    // With a limit of one, the beat after the start word overflows.
    write_limit(9'd1);
    put_word(START_WORD);
    put_word(16'hAAAA);
    // With a limit of two, the overflow falls on the check word itself.
    write_limit(9'd2);
    put_word(START_WORD);
    put_word(END_WORD);
    put_word(16'h5555);
    // A limit of zero turns every beat into an overflow, even while hunting.
    write_limit(9'd0);
    put_word(16'h5555);
    put_word(START_WORD);

    // Phase one: the sender idles little, the receiver stalls a lot.
    random_setting(9'd4, 55);
    random_setting(9'd511, 55);
    // The limit is capped at 256 words. This frame fills it exactly, so the
    // check word overflows and its position wraps the 8-bit index to zero.
    fill_body(254);
    send_frame(1'b1);

    // Phase two: the other way round.
    src_idle_pct  = 56;
    sink_idle_pct = 24;
    random_setting(9'd3, 55);
    random_setting(9'd256, 55);

    // Phase three: beats back to back on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_setting(9'd19, 55);
    random_setting(9'd256, 55);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fwdcrc_pkg.sv
hdl/fwdcrc_fsm.sv
hdl/framed_word_deframer_crc16.sv
test/framed_word_deframer_crc16_checker.sv
test/framed_word_deframer_crc16_tb.sv
